// ===== hw/rtl/bsa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the banker's safety allocator.
// Operation, status and register index codes. No dependencies.
package bsa_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_ALLOC = 2'd0,
        OP_LOAD_NEED  = 2'd1,
        OP_LOAD_AVAIL = 2'd2,
        OP_REQUEST    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_SHORT   = 2'd1,
        ST_EXCESS  = 2'd2,
        ST_UNSAFE  = 2'd3
    } t_status;

    localparam logic [1:0] CFG_PROC_COUNT = 2'd0;
    localparam logic [1:0] CFG_RES_COUNT  = 2'd1;

endpackage

// ===== hw/rtl/bankers_safety_allocator_top.sv =====
`timescale 1ns / 1ps
// Banker's safety allocator, top level.
// Depends on bsa_pkg and bsa_ram (allocation and need tables).
//
// Use: items enter on i_start while o_busy is low. Ops 0..2 load one entry of
// the allocation table, need table or available vector; they give no result
// and leave o_busy low. Op 3 is one element of a request; i_last closes it.
// Each request element is read from the need table, then checked.
// On the last element a bad request gives one registered result.
// A good one is granted on trial and swept for safety: each process visit
// reads and checks one resource at a time, set by the single read port of
// each table; a pass visits proc_count processes, and up to proc_count
// passes run. A safe grant then writes its row back one resource at a time
// and emits proc_count results, one a cycle, in safe order.
// Results appear for one cycle on o_valid; the receiver cannot stall.
// Configuration writes (i_cfg_valid, o_cfg_ready always high) are taken
// at any time but are meant for idle periods only.
// Reset (synchronous, i_rst_n low) clears tables by valid bits, the
// available vector and pending request; counts return to 8 and 4.
module bankers_safety_allocator_top
    import bsa_pkg::*;
#(
    parameter int MAX_PROCS   = 8,
    parameter int MAX_RES     = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_proc,
    input  logic [1:0]  i_res,
    input  logic [15:0] i_amount,
    input  logic        i_last,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_order_proc,
    output logic        o_end_of_run,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int DEPTH = MAX_PROCS * MAX_RES;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int PW    = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
    localparam int RW    = MAX_RES > 1 ? $clog2(MAX_RES) : 1;
    localparam int NPW   = $clog2(MAX_PROCS + 1);
    localparam int NRW   = $clog2(MAX_RES + 1);
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    typedef logic [COUNT_WIDTH-1:0] t_cnt;

    typedef enum logic [3:0] {
        S_IDLE, S_REQ, S_RD, S_CHK, S_ADD, S_NEXT, S_CM_RD, S_CM_WR, S_OUT
    } t_state;

    function automatic t_cnt f_sat_add(input t_cnt a, input t_cnt b);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        f_sat_add = s[COUNT_WIDTH] ? CMAX : s[COUNT_WIDTH-1:0];
    endfunction

    function automatic t_cnt f_sat_sub(input t_cnt a, input t_cnt b);
        f_sat_sub = (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [PW-1:0] p, input logic [RW-1:0] r);
        f_addr = AW'(int'(p) * MAX_RES + int'(r));
    endfunction

    t_state             r_state;
    logic [3:0]         r_pc;
    logic [2:0]         r_rc;
    t_cnt               r_avail [MAX_RES];
    t_cnt               r_pend  [MAX_RES];
    t_cnt               r_work  [MAX_RES];
    t_cnt               r_buf   [MAX_RES];
    logic [PW-1:0]      r_order [MAX_PROCS];
    logic [1:0]         r_err;
    logic [DEPTH-1:0]   r_avld;
    logic [DEPTH-1:0]   r_nvld;
    logic               r_avq;
    logic               r_nvq;
    logic [MAX_PROCS-1:0] r_fin;
    logic [NPW-1:0]     r_done;
    logic               r_prog;
    logic [PW-1:0]      r_i;
    logic [RW-1:0]      r_j;
    logic [PW-1:0]      r_sp;
    logic [PW-1:0]      r_k;
    logic [2:0]         r_p;
    logic [1:0]         r_r;
    t_cnt               r_amt;
    logic               r_last;
    logic               r_inr;
    logic               r_o_valid;
    logic [1:0]         r_o_status;
    logic [2:0]         r_o_order;
    logic               r_o_end;

    logic [NPW-1:0]     np;
    logic [NRW-1:0]     nr;
    t_cnt               amt_in;
    logic [AW-1:0]      addr_in;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               in_acc;
    logic               load_ok;
    logic               we_alloc;
    logic               we_need;
    t_cnt               wd_alloc;
    t_cnt               wd_need;
    t_cnt               rd_alloc;
    t_cnt               rd_need;
    t_cnt               alloc_v;
    t_cnt               need_v;
    t_cnt               alloc_eff;
    t_cnt               need_eff;
    t_cnt               pend_cur [MAX_RES];
    t_cnt               t_av [MAX_RES];

    // Effective counts: zero acts as one, above the maximum clamps.
    always_comb begin
        if (r_pc == 4'd0) np = NPW'(1);
        else if (int'(r_pc) > MAX_PROCS) np = NPW'(MAX_PROCS);
        else np = NPW'(r_pc);
        if (r_rc == 3'd0) nr = NRW'(1);
        else if (int'(r_rc) > MAX_RES) nr = NRW'(MAX_RES);
        else nr = NRW'(r_rc);
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_start && !o_busy;
    assign amt_in      = COUNT_WIDTH'(i_amount);
    assign addr_in     = f_addr(PW'(i_proc), RW'(i_res));
    assign load_ok     = (int'(i_proc) < MAX_PROCS) && (int'(i_res) < MAX_RES);

    // Unwritten table entries read as zero.
    assign alloc_v = r_avq ? rd_alloc : '0;
    assign need_v  = r_nvq ? rd_need  : '0;

    // Trial grant applies only to the requesting process row.
    assign alloc_eff = (r_i == r_sp) ? f_sat_add(alloc_v, r_pend[r_j]) : alloc_v;
    assign need_eff  = (r_i == r_sp) ? f_sat_sub(need_v, r_pend[r_j])  : need_v;

    // The element in hand joins the pending vector for the trial.
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            pend_cur[k] = (r_state == S_REQ && r_inr && k == int'(r_r)) ? r_amt : r_pend[k];
            t_av[k] = (k < int'(nr)) ? f_sat_sub(r_avail[k], pend_cur[k]) : r_avail[k];
        end
    end

    always_comb begin
        if (r_state == S_IDLE) begin
            raddr    = addr_in;
            waddr    = addr_in;
            wd_alloc = amt_in;
            wd_need  = amt_in;
            we_alloc = in_acc && load_ok && (i_op == OP_LOAD_ALLOC);
            we_need  = in_acc && load_ok && (i_op == OP_LOAD_NEED);
        end else begin
            raddr    = f_addr(r_i, r_j);
            waddr    = f_addr(r_i, r_j);
            wd_alloc = alloc_eff;
            wd_need  = need_eff;
            we_alloc = (r_state == S_CM_WR);
            we_need  = (r_state == S_CM_WR);
        end
    end

    bsa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_alloc (
        .i_clk   (i_clk),
        .i_we    (we_alloc),
        .i_waddr (waddr),
        .i_wdata (wd_alloc),
        .i_raddr (raddr),
        .o_rdata (rd_alloc)
    );

    bsa_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(DEPTH)) u_need (
        .i_clk   (i_clk),
        .i_we    (we_need),
        .i_waddr (waddr),
        .i_wdata (wd_need),
        .i_raddr (raddr),
        .o_rdata (rd_need)
    );

    always_ff @(posedge i_clk) begin
        logic [1:0] v_err;
        logic       v_valid;
        v_err   = r_err;
        v_valid = 1'b0;
        r_avq <= r_avld[raddr];
        r_nvq <= r_nvld[raddr];
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pc      <= 4'd8;
            r_rc      <= 3'd4;
            r_err     <= ST_GRANTED;
            r_avld    <= '0;
            r_nvld    <= '0;
            r_fin     <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < MAX_RES; k++) begin
                r_avail[k] <= '0;
                r_pend[k]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_PROC_COUNT) r_pc <= i_cfg_data;
                else if (i_cfg_index == CFG_RES_COUNT) r_rc <= i_cfg_data[2:0];
            end
            if (we_alloc) r_avld[waddr] <= 1'b1;
            if (we_need)  r_nvld[waddr] <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_op == OP_LOAD_AVAIL) begin
                            if (int'(i_res) < MAX_RES) r_avail[RW'(i_res)] <= amt_in;
                        end else if (i_op == OP_REQUEST) begin
                            r_p     <= i_proc;
                            r_r     <= i_res;
                            r_amt   <= amt_in;
                            r_last  <= i_last;
                            r_inr   <= (int'(i_proc) < int'(np)) && (int'(i_res) < int'(nr));
                            r_state <= S_REQ;
                        end
                    end
                end
                S_REQ: begin
                    if (r_inr && v_err == ST_GRANTED) begin
                        if (r_amt > r_avail[RW'(r_r)]) v_err = ST_SHORT;
                        else if (r_amt > need_v) v_err = ST_EXCESS;
                    end
                    if (r_last && v_err == ST_GRANTED && !(int'(r_p) < int'(np)))
                        v_err = ST_EXCESS;
                    if (!r_last) begin
                        if (r_inr) r_pend[RW'(r_r)] <= r_amt;
                        r_err   <= v_err;
                        r_state <= S_IDLE;
                    end else if (v_err != ST_GRANTED) begin
                        v_valid     = 1'b1;
                        r_o_status <= v_err;
                        r_o_order  <= 3'd0;
                        r_o_end    <= 1'b1;
                        r_err      <= ST_GRANTED;
                        for (int k = 0; k < MAX_RES; k++) r_pend[k] <= '0;
                        r_state    <= S_IDLE;
                    end else begin
                        if (r_inr) r_pend[RW'(r_r)] <= r_amt;
                        for (int k = 0; k < MAX_RES; k++) r_work[k] <= t_av[k];
                        r_fin   <= '0;
                        r_done  <= '0;
                        r_prog  <= 1'b0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sp    <= PW'(r_p);
                        r_err   <= ST_GRANTED;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= r_fin[r_i] ? S_NEXT : S_CHK;
                end
                S_CHK: begin
                    if (need_eff > r_work[r_j]) begin
                        r_j     <= '0;
                        r_state <= S_NEXT;
                    end else begin
                        r_buf[r_j] <= alloc_eff;
                        if (int'(r_j) == int'(nr) - 1) begin
                            r_state <= S_ADD;
                        end else begin
                            r_j     <= r_j + RW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_ADD: begin
                    for (int k = 0; k < MAX_RES; k++) begin
                        if (k < int'(nr)) r_work[k] <= f_sat_add(r_work[k], r_buf[k]);
                    end
                    r_fin[r_i]              <= 1'b1;
                    r_order[PW'(r_done)]    <= r_i;
                    r_done                  <= r_done + NPW'(1);
                    r_prog                  <= 1'b1;
                    r_j                     <= '0;
                    r_state                 <= S_NEXT;
                end
                S_NEXT: begin
                    if (int'(r_i) == int'(np) - 1) begin
                        if (r_done == np) begin
                            // Safe: write the trial row back.
                            r_i     <= r_sp;
                            r_j     <= '0;
                            r_state <= S_CM_RD;
                        end else if (!r_prog) begin
                            v_valid     = 1'b1;
                            r_o_status <= ST_UNSAFE;
                            r_o_order  <= 3'd0;
                            r_o_end    <= 1'b1;
                            for (int k = 0; k < MAX_RES; k++) r_pend[k] <= '0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_i     <= '0;
                            r_prog  <= 1'b0;
                            r_state <= S_RD;
                        end
                    end else begin
                        r_i     <= r_i + PW'(1);
                        r_state <= S_RD;
                    end
                end
                S_CM_RD: begin
                    r_state <= S_CM_WR;
                end
                S_CM_WR: begin
                    if (int'(r_j) == int'(nr) - 1) begin
                        for (int k = 0; k < MAX_RES; k++) begin
                            r_avail[k] <= t_av[k];
                            r_pend[k]  <= '0;
                        end
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + RW'(1);
                        r_state <= S_CM_RD;
                    end
                end
                S_OUT: begin
                    v_valid     = 1'b1;
                    r_o_status <= ST_GRANTED;
                    r_o_order  <= 3'(r_order[r_k]);
                    r_o_end    <= (int'(r_k) == int'(np) - 1);
                    if (int'(r_k) == int'(np) - 1) r_state <= S_IDLE;
                    else r_k <= r_k + PW'(1);
                end
                default: r_state <= S_IDLE;
            endcase
            r_o_valid <= v_valid;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_order_proc = r_o_order;
    assign o_end_of_run = r_o_end;

    // Anything but a grant is a single closing result.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_GRANTED) |-> (o_end_of_run && o_order_proc == 3'd0))
        else $error("error result not closing or carries a process");

    // A process is finished at most once per sweep.
    a_fin_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> !r_fin[r_i])
        else $error("process finished twice");

    // The finish count never passes the process count.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_done <= np))
        else $error("finish count overflow");

endmodule

// ===== hw/rtl/bsa_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
